>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file pfs_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is low.
`define PFS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define PFS_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Constants and types of the palette fade stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package pfs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int FADE_STEP       = 17;

    localparam int IDX_W   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W   = IDX_W + 1;
    localparam int COLOR_W = 24;
    localparam int TGT_W   = 27;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_COLOR  = 3'd1,
        OP_TARGET = 3'd2,
        OP_START  = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_EMIT
    } t_state;

    // Result item, red in the lowest bits.
    typedef struct packed {
        logic       fade_finished;
        logic       step_applied;
        logic       fading;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/pfs_ram.sv
// ----------------------------------------------------------------------------
// pfs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/palette_fade_stepper.sv
// ----------------------------------------------------------------------------
// palette_fade_stepper
// Palette fade engine: palette and fade targets in RAM, swept once per step.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser carries the operation (tick, write colour,
//   write target, start fade, read colour), tdata the index, colour, channel
//   mask and speed. Output stream m_axis returns exactly one item per input
//   item: the read colour and the fading / step / finished flags.
//   After reset the block runs a clearing pass over all 256 entries of both
//   RAMs (one entry a cycle) with s_axis_tready low.
//   One item is worked at a time. Writes, start, idle or counting ticks and
//   unused codes pass from the accepting edge through ST_EMIT (r_res) into
//   the output register, an in-range read first through ST_READ (the RAM
//   read); the next item is accepted once the block is back in ST_IDLE. A
//   stepping tick sweeps the palette one entry per cycle through the RAM
//   read/modify/write path; after the sweep its result passes through ST_EMIT.
//   The result waits in an output register; the next item is accepted while
//   it waits. When the receiver stalls with a result still held, the next
//   result parks in the block and input stalls until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_fade_stepper
    import pfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] entry_index, [15:8] red_in, [23:16] green_in, [31:24] blue_in,
    // [34:32] channel_valid, [42:35] speed_in, [47:43] zero
    input  wire logic [47:0] s_axis_tdata,
    // [2:0] operation
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [24] fading,
    // [25] step_applied, [26] fade_finished, [31:27] zero
    output logic [31:0]      m_axis_tdata
);

    localparam logic [CNT_W-1:0] ENTRY_LIM  = CNT_W'(PALETTE_ENTRIES);
    localparam logic [CNT_W-1:0] ENTRY_LAST = CNT_W'(PALETTE_ENTRIES - 1);
    localparam logic [7:0]       STEP8      = 8'(FADE_STEP);

    // Move one channel toward its target, landing on it when close.
    function automatic logic [7:0] approach(input logic [7:0] cur, input logic [7:0] tgt);
        logic [7:0] res;
        res = cur;
        if (tgt > cur) begin
            res = ((tgt - cur) <= STEP8) ? tgt : cur + STEP8;
        end else if (tgt < cur) begin
            res = ((cur - tgt) <= STEP8) ? tgt : cur - STEP8;
        end
        return res;
    endfunction

    t_state            r_state, n_state;
    logic [7:0]        r_rate, n_rate;
    logic [7:0]        r_tick, n_tick;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_wv, n_wv;
    logic [IDX_W-1:0]  r_waddr, n_waddr;
    logic              r_chg, n_chg;
    t_result           r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              pal_we, tgt_we;
    logic [IDX_W-1:0]  pal_waddr, tgt_waddr, rd_addr;
    logic [COLOR_W-1:0] pal_wdata, pal_rdata;
    logic [TGT_W-1:0]  tgt_wdata, tgt_rdata;

    logic              accept;
    t_op               in_op;
    logic [7:0]        in_idx;
    logic [COLOR_W-1:0] in_rgb;
    logic [2:0]        in_valid;
    logic [7:0]        in_speed;
    logic              in_range;

    logic [COLOR_W-1:0] step_col;
    logic              step_diff;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_op    = t_op'(s_axis_tuser);
    assign in_idx   = s_axis_tdata[7:0];
    assign in_rgb   = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
    assign in_valid = s_axis_tdata[34:32];
    assign in_speed = s_axis_tdata[42:35];
    assign in_range = ({1'b0, in_idx} < 9'(PALETTE_ENTRIES));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};

    pfs_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wdata),
        .i_raddr (rd_addr),
        .o_rdata (pal_rdata)
    );

    pfs_ram #(.WIDTH(TGT_W), .DEPTH(PALETTE_ENTRIES)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (tgt_waddr),
        .i_wdata (tgt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (tgt_rdata)
    );

    // Per-entry step: bit 24 red, bit 25 green, bit 26 blue take part.
    always_comb begin
        step_col[23:16] = tgt_rdata[24] ? approach(pal_rdata[23:16], tgt_rdata[23:16])
                                        : pal_rdata[23:16];
        step_col[15:8]  = tgt_rdata[25] ? approach(pal_rdata[15:8], tgt_rdata[15:8])
                                        : pal_rdata[15:8];
        step_col[7:0]   = tgt_rdata[26] ? approach(pal_rdata[7:0], tgt_rdata[7:0])
                                        : pal_rdata[7:0];
        step_diff       = (step_col != pal_rdata);
    end

    always_comb begin
        n_state     = r_state;
        n_rate      = r_rate;
        n_tick      = r_tick;
        n_cnt       = r_cnt;
        n_wv        = 1'b0;
        n_waddr     = r_waddr;
        n_chg       = r_chg;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        pal_we      = 1'b0;
        pal_waddr   = in_idx[IDX_W-1:0];
        pal_wdata   = in_rgb;
        tgt_we      = 1'b0;
        tgt_waddr   = in_idx[IDX_W-1:0];
        tgt_wdata   = {in_valid, in_rgb};
        rd_addr     = in_idx[IDX_W-1:0];

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                pal_we    = 1'b1;
                tgt_we    = 1'b1;
                pal_waddr = r_cnt[IDX_W-1:0];
                tgt_waddr = r_cnt[IDX_W-1:0];
                pal_wdata = '0;
                tgt_wdata = '0;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == ENTRY_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_res        = '0;
                    n_res.fading = (r_rate != 8'd0);
                    n_state      = ST_EMIT;
                    case (in_op)
                        OP_TICK: begin
                            if (r_rate != 8'd0) begin
                                if (r_tick < r_rate) begin
                                    n_tick = r_tick + 8'd1;
                                end else begin
                                    n_tick  = 8'd0;
                                    n_cnt   = '0;
                                    n_chg   = 1'b0;
                                    n_state = ST_STEP;
                                end
                            end
                        end
                        OP_COLOR: begin
                            pal_we = in_range;
                        end
                        OP_TARGET: begin
                            tgt_we = in_range;
                        end
                        OP_START: begin
                            n_rate       = in_speed;
                            n_tick       = 8'd0;
                            n_res.fading = (in_speed != 8'd0);
                        end
                        OP_READ: begin
                            if (in_range) begin
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_res.red   = pal_rdata[23:16];
                n_res.green = pal_rdata[15:8];
                n_res.blue  = pal_rdata[7:0];
                n_state     = ST_EMIT;
            end
            ST_STEP: begin
                // Issue the read of the next entry, write back the previous one.
                rd_addr = r_cnt[IDX_W-1:0];
                if (r_cnt != ENTRY_LIM) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_wv    = 1'b1;
                    n_waddr = r_cnt[IDX_W-1:0];
                end
                if (r_wv) begin
                    pal_we    = 1'b1;
                    pal_waddr = r_waddr;
                    pal_wdata = step_col;
                    n_chg     = r_chg | step_diff;
                    if (r_cnt == ENTRY_LIM) begin
                        n_res              = '0;
                        n_res.step_applied = 1'b1;
                        n_res.fading       = 1'b1;
                        if (!(r_chg | step_diff)) begin
                            n_rate              = 8'd0;
                            n_res.fading        = 1'b0;
                            n_res.fade_finished = 1'b1;
                        end
                        n_cnt   = '0;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rate      <= 8'd0;
            r_tick      <= 8'd0;
            r_cnt       <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rate      <= n_rate;
            r_tick      <= n_tick;
            r_cnt       <= n_cnt;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
        r_chg   <= n_chg;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

>>> hdl/pfs_checker.sv
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks of the palette fade stepper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pfs_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic [2:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata
);

    logic in_fire;
    logic [47:0] in_word;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_word = {s_axis_tuser[2:0] ^ s_axis_tuser[2:0], 45'd0} | s_axis_tdata;

    // Hold a stalled result.
    `PFS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")

    // Work one item at a time: input closes after an accept.
    `PFS_ASSERT(a_one_item, i_clk, i_rst_n, in_fire && (in_word == in_word) |=> !s_axis_tready, "input ready right after an accept")

    // End of fade only on a stepping tick, and it clears fading.
    `PFS_ASSERT(a_finish, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[25] && !m_axis_tdata[24], "fade end without step or still fading")

    // A stepping tick carries no colour.
    `PFS_NEVER(a_step_color, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[25] && (m_axis_tdata[23:0] != 24'd0), "colour on a stepping tick")

endmodule

bind palette_fade_stepper pfs_checker u_pfs_checker (.*);

`default_nettype wire
